[design/llta_pkg.sv]
// ----------------------------------------------------------------------------
// llta_pkg
// Shared types and constants for the lease lock token arbiter.
// ----------------------------------------------------------------------------
package llta_pkg;

  // Token counter width; granted_token carries the low 32 bits.
  localparam int unsigned TokenBits = 32;

  localparam logic [31:0] TtlResetMs = 32'd1000;

  localparam logic [2:0] ReplyLenGrant = 3'd6;
  localparam logic [2:0] ReplyLenShort = 3'd2;
  localparam logic [2:0] ReplyLenNone  = 3'd0;

  typedef enum logic [2:0] {
    KindEnter     = 3'd0,
    KindExit      = 3'd1,
    KindHeartbeat = 3'd2,
    KindReserved  = 3'd3,
    KindRevoke    = 3'd4
  } llta_kind_e;

  typedef enum logic [2:0] {
    StOk         = 3'd0,
    StRejected   = 3'd1,
    StBusy       = 3'd2,
    StBadToken   = 3'd3,
    StBadRequest = 3'd4
  } llta_status_e;

  // APB register word indexes
  typedef enum logic [0:0] {
    RegTtlMs = 1'b0
  } llta_reg_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] now_ms;
    logic [31:0] token_in;
    logic        has_token;
    logic        enter_allowed;
    logic [7:0]  device_state;
  } llta_req_t;

  typedef struct packed {
    logic         handled;
    llta_status_e status;
    logic         error_flag;
    logic [7:0]   state_byte;
    logic [31:0]  granted_token;
    logic [2:0]   reply_length;
  } llta_res_t;

endpackage

[design/llta_cfg.sv]
// ----------------------------------------------------------------------------
// llta_cfg
// APB register file holding the lease lifetime.
// ----------------------------------------------------------------------------
module llta_cfg
  import llta_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [31:0] ttl_ms_o
);

  logic [31:0] ttl_ms_q;
  logic [31:0] ttl_ms_d;
  logic        hit_ttl;

  // word index sits at paddr[2]
  assign hit_ttl = (paddr[2] == RegTtlMs);
  assign pready  = 1'b1;

  always_comb begin
    ttl_ms_d = ttl_ms_q;
    if (psel && penable && pwrite && hit_ttl) begin
      ttl_ms_d = pwdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ttl_ms_q <= TtlResetMs;
    end else begin
      ttl_ms_q <= ttl_ms_d;
    end
  end

  assign prdata   = hit_ttl ? ttl_ms_q : 32'd0;
  assign ttl_ms_o = ttl_ms_q;

endmodule

[design/llta_core.sv]
// ----------------------------------------------------------------------------
// llta_core
// Lock state registers and single-pass request evaluation.
// ----------------------------------------------------------------------------
module llta_core
  import llta_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  llta_req_t   req_i,
  input  logic [31:0] ttl_ms_i,
  output llta_res_t   res_o
);

  logic                 lock_held_q, lock_held_d;
  logic [TokenBits-1:0] holder_q, holder_d;
  logic [TokenBits-1:0] next_grant_q, next_grant_d;
  logic [31:0]          last_hb_q, last_hb_d;

  logic [31:0]          age;
  logic                 stale;
  logic                 held_eff;
  logic [TokenBits-1:0] grant_inc;
  logic                 tok_match;

  assign age       = req_i.now_ms - last_hb_q;
  assign stale     = lock_held_q && (age > ttl_ms_i);
  assign held_eff  = lock_held_q && !stale;
  assign grant_inc = next_grant_q + TokenBits'(1);
  assign tok_match = (64'(req_i.token_in) == 64'(holder_q));

  always_comb begin
    // stale drop applies to enter, exit, heartbeat and reserved
    lock_held_d  = held_eff;
    holder_d     = held_eff ? holder_q : '0;
    next_grant_d = next_grant_q;
    last_hb_d    = last_hb_q;

    res_o               = '0;
    res_o.status        = StOk;
    res_o.state_byte    = req_i.device_state;
    res_o.handled       = 1'b1;
    res_o.reply_length  = ReplyLenShort;

    case (req_i.kind)
      KindEnter: begin
        if (!req_i.enter_allowed) begin
          res_o.status = StRejected;
        end else if (held_eff) begin
          res_o.status = StBusy;
        end else begin
          lock_held_d         = 1'b1;
          holder_d            = next_grant_q;
          next_grant_d        = (grant_inc == '0) ? TokenBits'(1) : grant_inc;
          last_hb_d           = req_i.now_ms;
          res_o.granted_token = 32'(next_grant_q);
          res_o.reply_length  = ReplyLenGrant;
        end
      end
      KindExit, KindHeartbeat: begin
        if (!req_i.has_token) begin
          res_o.status     = StBadRequest;
          res_o.error_flag = 1'b1;
        end else if (!held_eff || !tok_match) begin
          res_o.status = StBadToken;
        end else if (req_i.kind == KindExit) begin
          lock_held_d = 1'b0;
          holder_d    = '0;
        end else begin
          last_hb_d = req_i.now_ms;
        end
      end
      KindReserved: begin
        res_o = '0;
      end
      KindRevoke: begin
        res_o       = '0;
        lock_held_d = 1'b0;
        holder_d    = '0;
      end
      default: begin
        // undefined kinds leave the state alone
        res_o       = '0;
        lock_held_d = lock_held_q;
        holder_d    = holder_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lock_held_q  <= 1'b0;
      holder_q     <= '0;
      next_grant_q <= TokenBits'(1);
      last_hb_q    <= '0;
    end else if (fire_i) begin
      lock_held_q  <= lock_held_d;
      holder_q     <= holder_d;
      next_grant_q <= next_grant_d;
      last_hb_q    <= last_hb_d;
    end
  end

endmodule

[design/lease_lock_token_arbiter_top.sv]
// ----------------------------------------------------------------------------
// lease_lock_token_arbiter_top
// Maintenance lease lock with heartbeat timeout, stream in/out, APB config.
// ----------------------------------------------------------------------------
// Path: from input transfer to the earliest result transfer, a request passes
//   through the input register, then evaluation into the result register.
// Throughput: one request per cycle unless the output stalls; the lock state
//   loop is a single subtract/compare/increment pass between the two registers.
// Reset (rst_ni low, async): lock free, token counter at 1, ttl_ms = 1000,
//   both pipeline stages empty.
// ----------------------------------------------------------------------------
module lease_lock_token_arbiter_top
  import llta_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,

  // request stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata: now_ms[31:0], token_in[63:32], has_token[64], enter_allowed[65],
  //        device_state[73:66], zero pad[79:74]
  input  logic [79:0] s_axis_tdata_i,
  // tuser: kind[2:0]
  input  logic [2:0]  s_axis_tuser_i,

  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tdata: handled[0], status[3:1], error_flag[4], state_byte[12:5],
  //        granted_token[44:13], reply_length[47:45]
  output logic [47:0] m_axis_tdata_o,

  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        in_valid_q;
  llta_req_t   in_req_q;
  logic        out_valid_q;
  llta_res_t   out_res_q;
  llta_res_t   res;
  logic        advance;
  logic [31:0] ttl_ms;

  llta_cfg u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .ttl_ms_o (ttl_ms)
  );

  // Request moves to the result stage when that stage is empty or draining;
  // the lock state commits on the same edge.
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  llta_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (advance),
    .req_i    (in_req_q),
    .ttl_ms_i (ttl_ms),
    .res_o    (res)
  );

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_req_q.kind          <= s_axis_tuser_i;
      in_req_q.now_ms        <= s_axis_tdata_i[31:0];
      in_req_q.token_in      <= s_axis_tdata_i[63:32];
      in_req_q.has_token     <= s_axis_tdata_i[64];
      in_req_q.enter_allowed <= s_axis_tdata_i[65];
      in_req_q.device_state  <= s_axis_tdata_i[73:66];
    end
  end

  // result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_res_q.reply_length, out_res_q.granted_token,
                            out_res_q.state_byte, out_res_q.error_flag,
                            out_res_q.status, out_res_q.handled};

endmodule
